FILE: rtl/salfu_pkg.sv
package salfu_pkg;

  localparam int FILES   = 1024;
  localparam int ENTRIES = 16;

  localparam int ID_W    = 10;
  localparam int SIZE_W  = 20;
  localparam int USED_W  = 21;
  localparam int CNT_W   = 16;
  localparam int EIDX_W  = $clog2(ENTRIES);
  localparam int FIDX_W  = $clog2(FILES);
  localparam int CLR_W   = FIDX_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BIG = 2'd1;
  localparam logic [1:0] ST_RES = 2'd2;

  typedef struct packed {
    logic load;
    logic clr;
    logic scan_init;
    logic scan_rd;
    logic evict;
    logic admit;
    logic bump;
  } cmd_t;

  typedef struct packed {
    logic            clear_done;
    logic            op;
    logic            resident;
    logic            oversize;
    logic            need;
    logic            any_valid;
    logic            scan_done;
    logic [ID_W-1:0] best_file;
  } sts_t;

endpackage

FILE: rtl/size_aware_lfu_cache_policy.sv
// Each eviction scans the entry table, one count-memory read per entry table slot.
// One item at a time: busy stays high until the item is done; results come one per
// strobe and cannot be stalled.
// After reset the count memory is zeroed, one word a cycle, with busy high; the
// capacity register can be written meanwhile.
module size_aware_lfu_cache_policy (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [salfu_pkg::ID_W-1:0]   in_file_id,
  input  logic [salfu_pkg::SIZE_W-1:0] in_file_size,
  output logic                         out_strobe,
  output logic                         out_evict_valid,
  output logic [salfu_pkg::ID_W-1:0]   out_evicted_id,
  output logic                         out_last,
  output logic [1:0]                   out_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import salfu_pkg::*;

  localparam logic [2:0] ADDR_CAPACITY = 3'd0;

  logic [SIZE_W-1:0] capacity_r;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? 32'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= {SIZE_W{1'b1}};
    end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
      capacity_r <= pwdata[SIZE_W-1:0];
    end
  end

  salfu_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .sts             (sts),
    .cmd             (cmd),
    .out_strobe      (out_strobe),
    .out_evict_valid (out_evict_valid),
    .out_evicted_id  (out_evicted_id),
    .out_last        (out_last),
    .out_status      (out_status)
  );

  salfu_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_op),
    .in_file_id   (in_file_id),
    .in_file_size (in_file_size),
    .capacity     (capacity_r),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

FILE: rtl/salfu_dp.sv
module salfu_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_op,
  input  logic [salfu_pkg::ID_W-1:0]   in_file_id,
  input  logic [salfu_pkg::SIZE_W-1:0] in_file_size,
  input  logic [salfu_pkg::SIZE_W-1:0] capacity,
  input  salfu_pkg::cmd_t              cmd,
  output salfu_pkg::sts_t              sts
);
  import salfu_pkg::*;

  logic [CNT_W-1:0]  cnt_mem [FILES];
  logic [CNT_W-1:0]  rdata_r;
  logic [FIDX_W-1:0] raddr;

  logic              op_r;
  logic [ID_W-1:0]   f_r;
  logic [SIZE_W-1:0] size_r;
  logic [USED_W-1:0] used_r;
  logic [CLR_W-1:0]  clr_cnt_r;

  logic [ENTRIES-1:0] ev_r;
  logic [ID_W-1:0]    ef_r [ENTRIES];
  logic [SIZE_W-1:0]  es_r [ENTRIES];

  logic [EIDX_W-1:0] idx_r;
  logic [EIDX_W-1:0] idx_d_r;
  logic              cmp_r;
  logic              best_vld_r;
  logic [EIDX_W-1:0] best_idx_r;
  logic [CNT_W-1:0]  best_cnt_r;
  logic [ID_W-1:0]   best_file_r;

  logic              resident;
  logic              free_found;
  logic [EIDX_W-1:0] free_idx;
  logic [USED_W:0]   sum;
  logic [ID_W-1:0]   cand_file;
  logic              better;

  always_comb begin
    resident   = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (ev_r[i] && ef_r[i] == f_r) resident = 1'b1;
      if (!ev_r[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = EIDX_W'(i);
      end
    end
  end

  assign sum       = {1'b0, used_r} + (USED_W+1)'(size_r);
  assign cand_file = ef_r[idx_d_r];
  assign better    = !best_vld_r || rdata_r < best_cnt_r ||
                     (rdata_r == best_cnt_r && cand_file < best_file_r);
  assign raddr     = cmd.scan_rd ? FIDX_W'(ef_r[idx_r]) : FIDX_W'(f_r);

  always_comb begin
    sts.clear_done = clr_cnt_r == CLR_W'(FILES);
    sts.op         = op_r;
    sts.resident   = resident;
    sts.oversize   = size_r > capacity;
    sts.need       = (sum > (USED_W+1)'(capacity)) || !free_found;
    sts.any_valid  = |ev_r;
    sts.scan_done  = idx_r == EIDX_W'(ENTRIES - 1);
    sts.best_file  = best_file_r;
  end

  always_ff @(posedge clk) begin
    rdata_r <= cnt_mem[raddr];
    if (cmd.clr) begin
      cnt_mem[clr_cnt_r[FIDX_W-1:0]] <= '0;
    end else if (cmd.bump) begin
      cnt_mem[FIDX_W'(f_r)] <= (rdata_r == CNT_MAX) ? rdata_r : rdata_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      ev_r       <= '0;
      used_r     <= '0;
      cmp_r      <= 1'b0;
      best_vld_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.load) begin
        op_r   <= in_op;
        f_r    <= in_file_id;
        size_r <= in_file_size;
      end
      cmp_r <= cmd.scan_rd;
      if (cmd.scan_init) begin
        idx_r      <= '0;
        best_vld_r <= 1'b0;
      end else if (cmd.scan_rd) begin
        idx_r   <= idx_r + 1'b1;
        idx_d_r <= idx_r;
      end
      if (cmp_r && ev_r[idx_d_r] && better) begin
        best_vld_r  <= 1'b1;
        best_idx_r  <= idx_d_r;
        best_cnt_r  <= rdata_r;
        best_file_r <= cand_file;
      end
      if (cmd.evict) begin
        ev_r[best_idx_r] <= 1'b0;
        used_r <= (used_r >= USED_W'(es_r[best_idx_r])) ?
                  used_r - USED_W'(es_r[best_idx_r]) : '0;
      end
      if (cmd.admit && free_found) begin
        ev_r[free_idx] <= 1'b1;
        ef_r[free_idx] <= f_r;
        es_r[free_idx] <= size_r;
        used_r         <= sum[USED_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/salfu_ctrl.sv
module salfu_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  salfu_pkg::sts_t            sts,
  output salfu_pkg::cmd_t            cmd,
  output logic                       out_strobe,
  output logic                       out_evict_valid,
  output logic [salfu_pkg::ID_W-1:0] out_evicted_id,
  output logic                       out_last,
  output logic [1:0]                 out_status
);
  import salfu_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_CHECK, S_SCAN, S_SCAN_END, S_EVICT, S_BRD, S_BWR
  } state_t;

  state_t          state_r, state_nxt;
  logic            strobe_r, evv_r, last_r, pend_r;
  logic [ID_W-1:0] evid_r, pend_id_r;
  logic [1:0]      status_r;

  assign busy            = state_r != S_IDLE;
  assign out_strobe      = strobe_r;
  assign out_evict_valid = evv_r;
  assign out_evicted_id  = evid_r;
  assign out_last        = last_r;
  assign out_status      = status_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_done) state_nxt = S_IDLE;
        else cmd.clr = 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op == OP_ACCESS) state_nxt = S_BRD;
        else if (sts.resident || sts.oversize) state_nxt = S_IDLE;
        else state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.need && sts.any_valid) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.admit = 1'b1;
          state_nxt = S_BRD;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_done) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: state_nxt = S_EVICT;
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_CHECK;
      end
      S_BRD: state_nxt = S_BWR;
      S_BWR: begin
        cmd.bump  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      strobe_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      unique case (state_r)
        S_DECODE: begin
          if (sts.op == OP_ACCESS || sts.resident || sts.oversize) begin
            strobe_r <= 1'b1;
            evv_r    <= 1'b0;
            evid_r   <= '0;
            last_r   <= 1'b1;
            if (sts.op == OP_ACCESS) status_r <= ST_OK;
            else if (sts.resident) status_r <= ST_RES;
            else status_r <= ST_BIG;
          end else begin
            strobe_r <= 1'b0;
          end
        end
        S_CHECK: begin
          status_r <= ST_OK;
          if (sts.need && sts.any_valid) begin
            strobe_r <= pend_r;
            evv_r    <= 1'b1;
            evid_r   <= pend_id_r;
            last_r   <= 1'b0;
          end else begin
            strobe_r <= 1'b1;
            evv_r    <= pend_r;
            evid_r   <= pend_r ? pend_id_r : '0;
            last_r   <= 1'b1;
          end
          pend_r <= 1'b0;
        end
        S_EVICT: begin
          strobe_r  <= 1'b0;
          pend_r    <= 1'b1;
          pend_id_r <= sts.best_file;
        end
        default: begin
          strobe_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: sim/tb_size_aware_lfu_cache_policy.sv
`timescale 1ns / 100ps

module tb_size_aware_lfu_cache_policy;
  import salfu_pkg::*;

  typedef struct packed {
    logic              evict_valid;
    logic [ID_W-1:0]   evicted_id;
    logic              last;
    logic [1:0]        status;
  } evict_word_t;

  typedef struct {
    logic              op;
    logic [ID_W-1:0]   file_id;
    logic [SIZE_W-1:0] file_size;
    bit                typed;
    evict_word_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [ID_W-1:0] in_file_id = '0;
  logic [SIZE_W-1:0] in_file_size = '0;
  logic out_strobe, out_evict_valid, out_last;
  logic [ID_W-1:0] out_evicted_id;
  logic [1:0] out_status;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  size_aware_lfu_cache_policy dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [CNT_W-1:0]  lfu_count [FILES];
  bit                slot_valid [ENTRIES];
  logic [ID_W-1:0]   slot_file [ENTRIES];
  logic [SIZE_W-1:0] slot_size [ENTRIES];
  logic [USED_W-1:0] used_total;
  logic [SIZE_W-1:0] cap_reg;

  evict_word_t pending_words[$];
  int errors = 0;

  function automatic void add_word(evict_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < ENTRIES; i++) if (!slot_valid[i]) return i;
    return -1;
  endfunction

  function automatic int lfu_victim();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!slot_valid[i]) continue;
      if (best < 0) best = i;
      else if (lfu_count[slot_file[i]] < lfu_count[slot_file[best]] ||
               (lfu_count[slot_file[i]] == lfu_count[slot_file[best]] &&
                slot_file[i] < slot_file[best])) best = i;
    end
    return best;
  endfunction

  function automatic void bump_count(logic [ID_W-1:0] f);
    if (lfu_count[f] != CNT_MAX) lfu_count[f]++;
  endfunction

  function automatic void predict_policy(logic op, logic [ID_W-1:0] f,
                                         logic [SIZE_W-1:0] sz);
    int n, v, s;
    bit resident;
    n = 0;
    resident = 0;
    if (op == OP_ACCESS) begin
      bump_count(f);
      add_word('{1'b0, '0, 1'b1, ST_OK});
      return;
    end
    for (int i = 0; i < ENTRIES; i++) if (slot_valid[i] && slot_file[i] == f) resident = 1;
    if (resident) begin
      add_word('{1'b0, '0, 1'b1, ST_RES});
      return;
    end
    if (sz > cap_reg) begin
      add_word('{1'b0, '0, 1'b1, ST_BIG});
      return;
    end
    while ((used_total + sz > cap_reg) || free_slot() < 0) begin
      v = lfu_victim();
      if (v < 0) break;
      slot_valid[v] = 0;
      used_total = (used_total >= slot_size[v]) ? used_total - slot_size[v] : '0;
      add_word('{1'b1, slot_file[v], 1'b0, ST_OK});
      n++;
    end
    s = free_slot();
    if (s >= 0) begin
      slot_valid[s] = 1;
      slot_file[s] = f;
      slot_size[s] = sz;
      used_total += sz;
    end
    bump_count(f);
    if (n == 0) add_word('{1'b0, '0, 1'b1, ST_OK});
    else pending_words[pending_words.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    evict_word_t w;
    if (rst_n && out_strobe) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: valid %0b id %0d last %0b status %0d",
               out_evict_valid, out_evicted_id, out_last, out_status);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (out_evict_valid !== w.evict_valid) begin
          $error("evict_valid expected %0b actual %0b", w.evict_valid, out_evict_valid);
          errors++;
        end
        if (out_evicted_id !== w.evicted_id) begin
          $error("evicted_id expected %0d actual %0d", w.evicted_id, out_evicted_id);
          errors++;
        end
        if (out_last !== w.last) begin
          $error("last expected %0b actual %0b", w.last, out_last);
          errors++;
        end
        if (out_status !== w.status) begin
          $error("status expected %0d actual %0d", w.status, out_status);
          errors++;
        end
      end
    end
  end

  task automatic write_capacity(logic [SIZE_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {12'($urandom_range(0, 4095)), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_reg = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(negedge clk);
  endtask

  task automatic issue(logic op, logic [ID_W-1:0] f, logic [SIZE_W-1:0] sz);
    @(negedge clk);
    in_op <= op;
    in_file_id <= f;
    in_file_size <= sz;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_policy(op, f, sz);
    @(negedge clk);
    start <= 1'b0;
    in_op <= 1'($urandom_range(0, 1));
    in_file_id <= ID_W'($urandom);
    in_file_size <= SIZE_W'($urandom);
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  dir_row_t dir_rows[] = '{
    '{OP_INSERT, 10'd5,    20'hFFFFF, 1'b1, '{1'b0, 10'd0, 1'b1, ST_OK}},
    '{OP_INSERT, 10'd5,    20'd1,     1'b1, '{1'b0, 10'd0, 1'b1, ST_RES}},
    '{OP_ACCESS, 10'd1023, 20'd0,     1'b1, '{1'b0, 10'd0, 1'b1, ST_OK}},
    '{OP_INSERT, 10'd0,    20'd0,     1'b0, '{default: '0}},
    '{OP_INSERT, 10'd1023, 20'd1,     1'b0, '{default: '0}},
    '{OP_ACCESS, 10'd0,    20'hFFFFF, 1'b1, '{1'b0, 10'd0, 1'b1, ST_OK}},
    '{OP_INSERT, 10'd7,    20'd3,     1'b0, '{default: '0}},
    '{OP_INSERT, 10'd8,    20'd3,     1'b0, '{default: '0}},
    '{OP_ACCESS, 10'd300,  20'd0,     1'b0, '{default: '0}},
    '{OP_INSERT, 10'd9,    20'hFFFFF, 1'b0, '{default: '0}}
  };

  task automatic fill_table(int base);
    for (int i = 0; i < ENTRIES + 2; i++) begin
      issue(OP_INSERT, ID_W'(base + i), SIZE_W'(i % 3));
      idle_gap();
    end
  endtask

  initial begin
    int hot [8];
    logic op;
    logic [ID_W-1:0] f;
    logic [SIZE_W-1:0] sz;
    for (int i = 0; i < FILES; i++) lfu_count[i] = '0;
    for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 0;
    used_total = '0;
    cap_reg = 20'hFFFFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].op, dir_rows[i].file_id, dir_rows[i].file_size);
      if (dir_rows[i].typed && pending_words.size() != 0 &&
          pending_words[pending_words.size()-1] != dir_rows[i].want) begin
        $error("status expected %0d actual %0d", dir_rows[i].want.status,
               pending_words[pending_words.size()-1].status);
        errors++;
      end
    end
    drain();
    write_capacity(20'd1);
    issue(OP_INSERT, 10'd40, 20'd2);
    issue(OP_INSERT, 10'd41, 20'd1);
    issue(OP_INSERT, 10'd42, 20'd0);
    drain();
    write_capacity(20'hFFFFF);
    fill_table(100);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_capacity(20'd16);
        1: write_capacity(20'd64);
        2: write_capacity(SIZE_W'($urandom_range(1, 20'hFFFFF)));
        default: write_capacity(20'hFFFFF);
      endcase
      foreach (hot[k]) hot[k] = $urandom_range(0, FILES - 1);
      for (int n = 0; n < 48; n++) begin
        op = $urandom_range(0, 99) < 60 ? OP_INSERT : OP_ACCESS;
        f = ($urandom_range(0, 3) != 0) ? ID_W'(hot[$urandom_range(0, 7)] +
            $urandom_range(0, 24)) : ID_W'($urandom);
        case ($urandom_range(0, 5))
          0: sz = SIZE_W'($urandom);
          1: sz = 20'hFFFFF;
          2: sz = '0;
          default: sz = (cap_reg < 20'd64) ?
                        SIZE_W'($urandom_range(0, cap_reg / 3 + 1)) :
                        SIZE_W'($urandom_range(0, cap_reg / 4));
        endcase
        issue(op, f, sz);
        idle_gap();
      end
      drain();
    end

    if (errors == 0) $display("PASS size_aware_lfu_cache_policy");
    else $display("FAIL size_aware_lfu_cache_policy");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL size_aware_lfu_cache_policy");
    $finish;
  end

endmodule
